[rtl/core/assert_macros.svh]
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/core/utf8sd_pkg.sv]
// shared types, constants and helpers for the utf-8 stream decoder
`timescale 1ns / 1ps
`default_nettype none

package utf8sd_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int CNT_W   = 2;
    localparam int BURST_W = 3;
    localparam int DEPTH   = 3;

    localparam logic [CP_W-1:0] REPL_CP  = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;
    localparam logic [CP_W-1:0] MIN_CP2  = 21'h000080;
    localparam logic [CP_W-1:0] MIN_CP3  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_CP4  = 21'h010000;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    // results caused by one input byte: all replacements but the final one
    typedef struct packed {
        logic [BURST_W-1:0] count;
        logic [CP_W-1:0]    cp;
        logic               rep;
        logic               done;
    } burst_t;

    // sequence length announced by a lead byte, none for anything else
    function automatic logic [2:0] seq_len(input logic [BYTE_W-1:0] b);
        logic [2:0] len;
        begin
            if (b[7:5] == 3'b110) begin
                len = LEN_TWO;
            end else if (b[7:4] == 4'b1110) begin
                len = LEN_THREE;
            end else if (b[7:3] == 5'b11110) begin
                len = LEN_FOUR;
            end else begin
                len = LEN_NONE;
            end
            return len;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/utf8sd_decode.sv]
// sequence tracking: held bytes, byte classification and result burst
`timescale 1ns / 1ps
`default_nettype none

module utf8sd_decode (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          accept,
    input  wire logic [utf8sd_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                          string_end,
    output utf8sd_pkg::burst_t                 burst
);
    import utf8sd_pkg::*;

    logic [BYTE_W-1:0] pend_reg [0:DEPTH-1];
    logic [BYTE_W-1:0] pend_next [0:DEPTH-1];
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    logic [2:0]        need;
    logic              is_cont;
    logic              lead_store;
    logic [CP_W-1:0]   lead_cp;
    logic              lead_rep;
    logic [CP_W-1:0]   fin_cp;
    logic              fin_bad;
    logic              have_main;
    logic [CP_W-1:0]   main_cp;
    logic              main_rep;
    logic [CNT_W-1:0]  pre_cnt;
    logic [CNT_W-1:0]  mid_cnt;
    logic [CNT_W-1:0]  post_cnt;

    assign need       = seq_len(pend_reg[0]);
    assign is_cont    = (in_byte[7:6] == 2'b10);
    assign lead_store = (seq_len(in_byte) != LEN_NONE);
    assign lead_cp    = in_byte[7] ? REPL_CP : {{(CP_W-BYTE_W){1'b0}}, in_byte};
    assign lead_rep   = in_byte[7];

    // assemble the completed scalar with the current byte as the last one
    always_comb begin
        case (need)
            LEN_TWO: begin
                fin_cp  = {10'd0, pend_reg[0][4:0], in_byte[5:0]};
                fin_bad = (fin_cp < MIN_CP2);
            end
            LEN_THREE: begin
                fin_cp  = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0], in_byte[5:0]};
                fin_bad = (fin_cp < MIN_CP3);
            end
            default: begin
                fin_cp  = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0],
                           in_byte[5:0]};
                fin_bad = (fin_cp < MIN_CP4) || (fin_cp > MAX_CP);
            end
        endcase
    end

    always_comb begin
        pend_next = pend_reg;
        pre_cnt   = '0;
        mid_cnt   = '0;
        have_main = 1'b0;
        main_cp   = REPL_CP;
        main_rep  = 1'b1;
        if (cnt_reg != '0 && is_cont) begin
            if ({1'b0, cnt_reg} + 3'd1 >= need) begin
                have_main = 1'b1;
                main_cp   = fin_bad ? REPL_CP : fin_cp;
                main_rep  = fin_bad;
            end else begin
                mid_cnt = cnt_reg + 2'd1;
                case (cnt_reg)
                    2'd1:    pend_next[1] = in_byte;
                    default: pend_next[2] = in_byte;
                endcase
            end
        end else begin
            // flush held bytes; a lead byte is then held, others give a result
            pre_cnt = cnt_reg;
            if (lead_store) begin
                mid_cnt      = 2'd1;
                pend_next[0] = in_byte;
            end else begin
                have_main = 1'b1;
                main_cp   = lead_cp;
                main_rep  = lead_rep;
            end
        end
        post_cnt = string_end ? mid_cnt : '0;
        cnt_next = string_end ? '0 : mid_cnt;
    end

    always_comb begin
        burst.count = {1'b0, pre_cnt} + {2'b00, have_main} + {1'b0, post_cnt};
        burst.cp    = (post_cnt == '0 && have_main) ? main_cp : REPL_CP;
        burst.rep   = (post_cnt == '0 && have_main) ? main_rep : 1'b1;
        burst.done  = string_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (accept) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg <= pend_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/utf8sd_emit.sv]
// result register: plays out the replacements and final result of one byte
`timescale 1ns / 1ps
`default_nettype none

module utf8sd_emit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        load,
    input  wire utf8sd_pkg::burst_t          burst,
    output logic                             ready,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [utf8sd_pkg::CP_W-1:0]      code_point,
    output logic                             is_replacement,
    output logic                             last_in_run,
    output logic                             string_done
);
    import utf8sd_pkg::*;

    logic                 valid_reg;
    logic [BURST_W-1:0]   rem_reg;
    logic [CP_W-1:0]      cp_reg;
    logic                 rep_reg;
    logic                 done_reg;
    logic                 at_last;

    assign at_last        = (rem_reg == 3'd1);
    assign ready          = !valid_reg || (out_ready && at_last);
    assign out_valid      = valid_reg;
    assign code_point     = at_last ? cp_reg : REPL_CP;
    assign is_replacement = at_last ? rep_reg : 1'b1;
    assign last_in_run    = at_last;
    assign string_done    = at_last && done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            rem_reg   <= burst.count;
        end else if (valid_reg && out_ready) begin
            rem_reg <= rem_reg - 3'd1;
            if (at_last) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cp_reg   <= burst.cp;
            rep_reg  <= burst.rep;
            done_reg <= burst.done;
        end
    end

endmodule

`default_nettype wire

[rtl/core/utf8_stream_decoder.sv]
// streaming utf-8 decoder, one byte in per transaction, one code point out per transaction
// the first result of a byte is registered and shown in the cycle after the byte is taken
// throughput: one byte per cycle while each byte yields at most one result and m_tready stays high
// a byte that flushes held bytes keeps the result register busy until its last result is taken
// sync reset (aresetn low) empties the held-byte count and drops any pending result
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte[7:0]
    input  wire logic        s_tlast,   // string_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // code_point[20:0], zero pad[23:21]
    output logic [1:0]       m_tuser,   // is_replacement[0], string_done[1]
    output logic             m_tlast    // last_in_run
);
    import utf8sd_pkg::*;

    logic            accept;
    logic            load;
    burst_t          burst;
    logic [CP_W-1:0] code_point;
    logic            is_replacement;
    logic            string_done;

    assign accept = s_tvalid && s_tready;
    // bytes that only start or extend a held sequence give no transaction
    assign load   = accept && (burst.count != '0);

    utf8sd_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .in_byte    (s_tdata),
        .string_end (s_tlast),
        .burst      (burst)
    );

    utf8sd_emit u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (load),
        .burst          (burst),
        .ready          (s_tready),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .code_point     (code_point),
        .is_replacement (is_replacement),
        .last_in_run    (m_tlast),
        .string_done    (string_done)
    );

    assign m_tdata = {{(24-CP_W){1'b0}}, code_point};
    assign m_tuser = {string_done, is_replacement};

endmodule

`default_nettype wire

[rtl/core/utf8sd_checker.sv]
// port-level checks for the utf-8 stream decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module utf8sd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // a stalled result transaction holds
    `ASSERT_CLKD(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // string end only on the last result of a byte
    `ASSERT_CLKD(a_done_last, m_tvalid && m_tuser[1] |-> m_tlast, "string_done without last_in_run")

    // leading results of a byte are always replacements
    `ASSERT_CLKD(a_lead_repl, m_tvalid && !m_tlast |-> m_tuser[0] && m_tdata[20:0] == 21'h00FFFD, "non-final result is not U+FFFD")

    // decoded values stay within the unicode range
    `ASSERT_CLKD(a_range, m_tvalid && !m_tuser[0] |-> m_tdata[20:0] <= 21'h10FFFF && m_tdata[23:21] == 3'd0, "decoded value out of range")

    // nothing is offered in the cycle after reset
    `ASSERT_ALWAYS(a_reset, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind utf8_stream_decoder utf8sd_checker u_utf8sd_checker (.*);

`default_nettype wire

[sim/utf8_stream_decoder_test.sv]
// self-checking testbench for the utf-8 stream decoder
`timescale 1ns / 1ps

module utf8_stream_decoder_test;
    import utf8sd_pkg::*;

    localparam int RANDOM_ITEMS = 390;
    localparam int SINK_HOLD    = 150;

    // predicts the code points for every accepted byte and checks them in order
    class code_point_board;
        typedef struct packed {
            logic [20:0] cp;
            logic        rep;
            logic        last;
            logic        done;
        } point_t;

        point_t      expected_points[$];
        point_t      burst[$];
        logic [7:0]  held_bytes[3];
        int unsigned held_count;
        int unsigned mismatches;

        function new();
            held_count = 0;
            mismatches = 0;
        endfunction

        function int unsigned lead_len(logic [7:0] b);
            casez (b)
                8'b110?_????: return 2;
                8'b1110_????: return 3;
                8'b1111_0???: return 4;
                default:      return 0;
            endcase
        endfunction

        function void add_point(logic [20:0] cp, logic rep);
            burst.insert(burst.size(), {cp, rep, 1'b0, 1'b0});
        endfunction

        function void flush_held();
            for (int unsigned i = 0; i < held_count; i++) add_point(REPL_CP, 1'b1);
            held_count = 0;
        endfunction

        function void start_sequence(logic [7:0] b);
            if (b[7] == 1'b0) begin
                add_point({13'd0, b}, 1'b0);
            end else if (lead_len(b) != 0) begin
                held_bytes[0] = b;
                held_count = 1;
            end else begin
                add_point(REPL_CP, 1'b1);
            end
        endfunction

        function void complete_sequence(logic [7:0] b);
            logic [20:0] cp;
            logic        bad;
            case (lead_len(held_bytes[0]))
                2: begin
                    cp  = {10'd0, held_bytes[0][4:0], b[5:0]};
                    bad = cp < MIN_CP2;
                end
                3: begin
                    cp  = {5'd0, held_bytes[0][3:0], held_bytes[1][5:0], b[5:0]};
                    bad = cp < MIN_CP3;
                end
                default: begin
                    cp  = {held_bytes[0][2:0], held_bytes[1][5:0],
                           held_bytes[2][5:0], b[5:0]};
                    bad = cp < MIN_CP4 || cp > MAX_CP;
                end
            endcase
            held_count = 0;
            if (bad) add_point(REPL_CP, 1'b1);
            else add_point(cp, 1'b0);
        endfunction

        function void note_byte(logic [7:0] b, logic string_end);
            burst.delete();
            if (held_count == 0) begin
                start_sequence(b);
            end else if (b[7:6] == 2'b10) begin
                if (held_count + 1 >= lead_len(held_bytes[0])) begin
                    complete_sequence(b);
                end else begin
                    held_bytes[held_count] = b;
                    held_count++;
                end
            end else begin
                flush_held();
                start_sequence(b);
            end
            if (string_end) flush_held();
            if (burst.size() > 0) begin
                burst[burst.size()-1].last = 1'b1;
                burst[burst.size()-1].done = string_end;
            end
            foreach (burst[i]) expected_points.insert(expected_points.size(), burst[i]);
        endfunction

        function void check_point(logic [20:0] cp, logic rep, logic last, logic done);
            point_t got;
            point_t want;
            got = {cp, rep, last, done};
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: cp %h rep %b last %b done %b",
                             cp, rep, last, done);
            end else begin
                want = expected_points.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                                 want.cp, want.rep, want.last, want.done,
                                 cp, rep, last, done);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_points.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    code_point_board board;
    logic [7:0]      text_bytes[$];
    int unsigned     items_sent;
    int              src_calm;
    int              sink_calm;
    bit              sink_hold_req;
    bit              reset_done;

    // {string_end, byte}
    logic [8:0] directed_items[] = '{
        9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0EF, 9'h0BF, 9'h0BF,
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h0FF, 9'h080, 9'h0C0, 9'h080,
        9'h0E0, 9'h080, 9'h080, 9'h0F5, 9'h080, 9'h080, 9'h180,
        9'h0E2, 9'h082, 9'h041, 9'h1C3, 9'h0F0, 9'h090, 9'h080, 9'h141
    };

    utf8_stream_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // in_byte[7:0]
        .s_tlast  (s_tlast),   // string_end
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // code_point[20:0], zero pad[23:21]
        .m_tuser  (m_tuser),   // is_replacement[0], string_done[1]
        .m_tlast  (m_tlast)    // last_in_run
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // mostly random gaps, with the odd run of back-to-back transactions
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic string_end);
        int gap;
        gap = draw_gap(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= string_end;
        do @(posedge aclk); while (!s_tready);
        board.note_byte(b, string_end);
        items_sent++;
        @(negedge aclk);
    endtask

    // stop offering bytes until every predicted code point has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic void add_byte(input logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endfunction

    task automatic encode_char(input int unsigned len, input logic [20:0] cp);
        case (len)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_unit();
        int unsigned kind;
        int unsigned len;
        int unsigned cut;
        logic [20:0] cp;
        kind = $urandom_range(0, 99);
        len  = $urandom_range(1, 4);
        // a quarter of the characters take any value their length can carry
        if ($urandom_range(0, 3) == 0) begin
            case (len)
                1: cp = 21'($urandom_range(0, 'h7F));
                2: cp = 21'($urandom_range(0, 'h7FF));
                3: cp = 21'($urandom_range(0, 'hFFFF));
                default: cp = 21'($urandom_range(0, 'h1FFFFF));
            endcase
        end else begin
            case (len)
                1: cp = 21'($urandom_range(0, 'h7F));
                2: cp = 21'($urandom_range('h80, 'h7FF));
                3: cp = 21'($urandom_range('h800, 'hFFFF));
                default: cp = 21'($urandom_range('h10000, 'h10FFFF));
            endcase
        end
        if (kind < 70) begin
            encode_char(len, cp);
        end else if (kind < 78) begin
            add_byte({2'b10, 6'($urandom_range(0, 63))});
        end else if (kind < 84) begin
            add_byte(8'($urandom_range('hF8, 'hFF)));
        end else if (kind < 94) begin
            // sequence cut short, so a following non-continuation byte or the string end breaks it
            if (len == 1) len = 2;
            encode_char(len, cp);
            cut = $urandom_range(1, len - 1);
            repeat (cut) void'(text_bytes.pop_back());
        end else begin
            add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_text();
        int unsigned units;
        text_bytes.delete();
        units = $urandom_range(1, 6);
        repeat (units) add_unit();
        foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    // result side: random back-pressure, plus one long hold when asked
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (reset_done);
        @(negedge aclk);
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                gap = SINK_HOLD;
            end else begin
                gap = draw_gap(sink_calm);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_point(m_tdata[20:0], m_tuser[0], m_tlast, m_tuser[1]);
    end

    initial begin
        bit hold_asked;
        bit pause_done;
        board         = new();
        items_sent    = 0;
        src_calm      = 0;
        sink_calm     = 0;
        sink_hold_req = 1'b0;
        reset_done    = 1'b0;
        hold_asked    = 1'b0;
        pause_done    = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tlast       = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn    <= 1'b1;
        reset_done = 1'b1;
        @(negedge aclk);

        foreach (directed_items[i]) send_byte(directed_items[i][7:0], directed_items[i][8]);
        drain();

        while (items_sent < directed_items.size() + RANDOM_ITEMS) begin
            if (!hold_asked && items_sent > 150) begin
                hold_asked    = 1'b1;
                sink_hold_req = 1'b1;
            end
            if (!pause_done && items_sent > 300) begin
                pause_done = 1'b1;
                drain();
            end
            send_text();
        end

        drain();
        repeat (10) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("utf8_stream_decoder test passed");
        else
            $display("utf8_stream_decoder test failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("utf8_stream_decoder test failed");
        $finish;
    end

endmodule
